@@ sv/sdid_pkg.sv @@
// Package for the SD card identification sequencer.
// Holds the phase enum, command and failure codes, and the result word type.
// No dependencies.
package sdid_pkg;

  // Sequencer phase: which command outcome is awaited
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_CMD0   = 3'd1,
    PH_CMD8   = 3'd2,
    PH_CMD55  = 3'd3,
    PH_ACMD41 = 3'd4
  } phase_t;

  // Command indexes
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_IF   = 6'd8;
  localparam logic [5:0] CMD_APP       = 6'd55;
  localparam logic [5:0] CMD_SD_OP_COND = 6'd41;

  // Failure codes
  localparam logic [2:0] FAIL_NONE    = 3'd0;
  localparam logic [2:0] FAIL_CMD0    = 3'd1;
  localparam logic [2:0] FAIL_CMD8    = 3'd2;
  localparam logic [2:0] FAIL_PATTERN = 3'd3;
  localparam logic [2:0] FAIL_VOLTAGE = 3'd4;
  localparam logic [2:0] FAIL_CMD55   = 3'd5;
  localparam logic [2:0] FAIL_ACMD41  = 3'd6;
  localparam logic [2:0] FAIL_RETRIES = 3'd7;

  // Card versions
  localparam logic [1:0] VER_UNKNOWN = 2'd0;
  localparam logic [1:0] VER_2       = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_TRIES     = 2'd0;
  localparam logic [1:0] REG_CHECK_PATTERN = 2'd1;
  localparam logic [1:0] REG_REQ_HC        = 2'd2;

  // Configuration reset values
  localparam logic [7:0] MAX_TRIES_RST     = 8'd100;
  localparam logic [7:0] CHECK_PATTERN_RST = 8'hAA;

  // Argument bits
  localparam int VHS_BIT  = 8;   // 2.7-3.6 V supply in CMD8 argument and echo
  localparam int HCS_BIT  = 30;  // high capacity request in ACMD41 argument
  localparam int BUSY_BIT = 31;  // power-up done in OCR

  localparam logic [7:0] TRIES_SAT = 8'hFF;

  // Input request kinds
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_OUTCOME = 1'b1;

  // One result word
  typedef struct packed {
    logic        issue_cmd;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic        expect_response;
    logic        send_init_seq;
    logic        delay_first;
    logic        done_res;
    logic        success;
    logic [2:0]  fail_code;
    logic [1:0]  card_version;
    logic [31:0] ocr_value;
  } res_t;

endpackage

@@ sv/sdid_if.sv @@
// Channel interfaces for the SD card identification sequencer.
// Input, result and configuration channels; valid/ready handshake.
// Depends on nothing.
interface sdid_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        cmd_ok;
  logic [31:0] response_word;

  modport source (output valid, output req_type, output cmd_ok, output response_word,
                  input ready);
  modport sink (input valid, input req_type, input cmd_ok, input response_word,
                output ready);
endinterface

interface sdid_out_if;
  logic        valid;
  logic        ready;
  logic        issue_cmd;
  logic [5:0]  cmd_index;
  logic [31:0] cmd_argument;
  logic        expect_response;
  logic        send_init_seq;
  logic        delay_first;
  logic        done_res;
  logic        success;
  logic [2:0]  fail_code;
  logic [1:0]  card_version;
  logic [31:0] ocr_value;

  modport source (output valid, output issue_cmd, output cmd_index, output cmd_argument,
                  output expect_response, output send_init_seq, output delay_first,
                  output done_res, output success, output fail_code,
                  output card_version, output ocr_value, input ready);
  modport sink (input valid, input issue_cmd, input cmd_index, input cmd_argument,
                input expect_response, input send_init_seq, input delay_first,
                input done_res, input success, input fail_code,
                input card_version, input ocr_value, output ready);
endinterface

interface sdid_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/sd_card_identification_sequencer.sv @@
// Top level of the SD card identification sequencer.
// Uses sdid_pkg for types and codes and sdid_if.sv for the channel interfaces.
//
// Usage:
//   in_if  : one word per request. req_type 0 starts (or restarts) the
//            CMD0 / CMD8 / CMD55 / ACMD41 identification order; req_type 1
//            reports the outcome (cmd_ok, response_word) of the last command.
//   out_if : one word per start and per outcome while a command is pending:
//            either the next command to issue or a done word carrying
//            success, failure code, card version and OCR. An outcome that
//            arrives while idle is consumed and yields no word.
//   cfg_if : register writes (0 max_tries, 1 check_pattern,
//            2 request_high_capacity), always ready; write only while idle.
// An accepted word is held in the input register, then the result register loads
// from it once the result register is free. Throughput is one word per cycle while
// the receiver takes results, with the phase update between the two registers.
// Reset (rst_n low, synchronous) returns the phase to idle, clears the try
// count and version, and loads the register defaults (100, 0xAA, 1).
// When the receiver stalls, the result register holds its word, the input
// register fills, and in_if.ready drops until the result is taken.
module sd_card_identification_sequencer (
  input  logic          clk,
  input  logic          rst_n,
  sdid_in_if.sink       in_if,
  sdid_out_if.source    out_if,
  sdid_cfg_if.sink      cfg_if
);
  import sdid_pkg::*;

  // Configuration registers
  logic [7:0] max_tries_r;
  logic [7:0] check_pattern_r;
  logic       req_hc_r;

  // Input register
  logic        s1_valid_r;
  logic        s1_req_r;
  logic        s1_ok_r;
  logic [31:0] s1_resp_r;

  // Sequencer state
  phase_t     phase_r, phase_nxt;
  logic [7:0] tries_r, tries_nxt;
  logic [1:0] ver_r, ver_nxt;

  // Result register
  logic out_valid_r, out_valid_nxt;
  res_t res_r, res_nxt;
  logic has_res;

  // Shared decode of the pending item
  logic       advance;
  logic       pattern_ok;
  logic       volt_ok;
  logic       busy_done;
  logic [7:0] tries_inc;
  logic       tries_out;

  assign advance    = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || advance;
  assign cfg_if.ready = 1'b1;

  assign pattern_ok = (s1_resp_r[7:0] == check_pattern_r);
  assign volt_ok    = s1_resp_r[VHS_BIT];
  assign busy_done  = s1_resp_r[BUSY_BIT];
  assign tries_inc  = (tries_r != TRIES_SAT) ? tries_r + 8'd1 : tries_r;
  assign tries_out  = (tries_inc >= max_tries_r);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tries_r     <= MAX_TRIES_RST;
      check_pattern_r <= CHECK_PATTERN_RST;
      req_hc_r        <= 1'b1;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_MAX_TRIES:     max_tries_r     <= cfg_if.data;
        REG_CHECK_PATTERN: check_pattern_r <= cfg_if.data;
        REG_REQ_HC:        req_hc_r        <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      s1_req_r  <= in_if.req_type;
      s1_ok_r   <= in_if.cmd_ok;
      s1_resp_r <= in_if.response_word;
    end
  end

  // Next state of the sequencer
  always_comb begin
    phase_nxt = phase_r;
    tries_nxt = tries_r;
    ver_nxt   = ver_r;
    if (s1_req_r == REQ_START) begin
      phase_nxt = PH_CMD0;
      tries_nxt = '0;
      ver_nxt   = VER_UNKNOWN;
    end else begin
      case (phase_r)
        PH_CMD0: begin
          phase_nxt = s1_ok_r ? PH_CMD8 : PH_IDLE;
        end
        PH_CMD8: begin
          if (s1_ok_r && pattern_ok && volt_ok) begin
            phase_nxt = PH_CMD55;
            ver_nxt   = VER_2;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_CMD55: begin
          phase_nxt = s1_ok_r ? PH_ACMD41 : PH_IDLE;
        end
        PH_ACMD41: begin
          if (s1_ok_r) begin
            tries_nxt = tries_inc;
            phase_nxt = (busy_done || tries_out) ? PH_IDLE : PH_CMD55;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Result word for the pending item
  always_comb begin
    res_nxt              = '0;
    res_nxt.card_version = VER_UNKNOWN;
    has_res              = 1'b1;
    if (s1_req_r == REQ_START) begin
      res_nxt.issue_cmd     = 1'b1;
      res_nxt.cmd_index     = CMD_GO_IDLE;
      res_nxt.send_init_seq = 1'b1;
    end else begin
      case (phase_r)
        PH_CMD0: begin
          if (s1_ok_r) begin
            res_nxt.issue_cmd       = 1'b1;
            res_nxt.cmd_index       = CMD_SEND_IF;
            res_nxt.cmd_argument    = {23'd0, 1'b1, check_pattern_r};
            res_nxt.expect_response = 1'b1;
          end else begin
            res_nxt.done_res     = 1'b1;
            res_nxt.fail_code    = FAIL_CMD0;
            res_nxt.card_version = ver_r;
          end
        end
        PH_CMD8: begin
          if (s1_ok_r && pattern_ok && volt_ok) begin
            res_nxt.issue_cmd       = 1'b1;
            res_nxt.cmd_index       = CMD_APP;
            res_nxt.expect_response = 1'b1;
          end else begin
            res_nxt.done_res     = 1'b1;
            res_nxt.card_version = ver_r;
            if (!s1_ok_r) begin
              res_nxt.fail_code = FAIL_CMD8;
            end else if (!pattern_ok) begin
              res_nxt.fail_code = FAIL_PATTERN;
            end else begin
              res_nxt.fail_code = FAIL_VOLTAGE;
            end
          end
        end
        PH_CMD55: begin
          if (s1_ok_r) begin
            res_nxt.issue_cmd                 = 1'b1;
            res_nxt.cmd_index                 = CMD_SD_OP_COND;
            res_nxt.cmd_argument[HCS_BIT]     = req_hc_r;
            res_nxt.expect_response           = 1'b1;
          end else begin
            res_nxt.done_res     = 1'b1;
            res_nxt.fail_code    = FAIL_CMD55;
            res_nxt.card_version = ver_r;
          end
        end
        PH_ACMD41: begin
          if (!s1_ok_r) begin
            res_nxt.done_res     = 1'b1;
            res_nxt.fail_code    = FAIL_ACMD41;
            res_nxt.card_version = ver_r;
          end else if (busy_done) begin
            res_nxt.done_res     = 1'b1;
            res_nxt.success      = 1'b1;
            res_nxt.fail_code    = FAIL_NONE;
            res_nxt.card_version = ver_r;
            res_nxt.ocr_value    = s1_resp_r;
          end else if (tries_out) begin
            res_nxt.done_res     = 1'b1;
            res_nxt.fail_code    = FAIL_RETRIES;
            res_nxt.card_version = ver_r;
          end else begin
            // repeat the pair after the retry delay
            res_nxt.issue_cmd       = 1'b1;
            res_nxt.cmd_index       = CMD_APP;
            res_nxt.expect_response = 1'b1;
            res_nxt.delay_first     = 1'b1;
          end
        end
        default: begin
          // outcome with no command pending: drop it
          has_res = 1'b0;
        end
      endcase
    end
  end

  // Result valid: set on a new word, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && has_res) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Advance the sequencer and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tries_r     <= '0;
      ver_r       <= VER_UNKNOWN;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        phase_r <= phase_nxt;
        tries_r <= tries_nxt;
        ver_r   <= ver_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_res) begin
      res_r <= res_nxt;
    end
  end

  // Drive the result channel
  assign out_if.valid           = out_valid_r;
  assign out_if.issue_cmd       = res_r.issue_cmd;
  assign out_if.cmd_index       = res_r.cmd_index;
  assign out_if.cmd_argument    = res_r.cmd_argument;
  assign out_if.expect_response = res_r.expect_response;
  assign out_if.send_init_seq   = res_r.send_init_seq;
  assign out_if.delay_first     = res_r.delay_first;
  assign out_if.done_res        = res_r.done_res;
  assign out_if.success         = res_r.success;
  assign out_if.fail_code       = res_r.fail_code;
  assign out_if.card_version    = res_r.card_version;
  assign out_if.ocr_value       = res_r.ocr_value;

endmodule
